// ===== hw/rtl/whp_pkg.sv =====
`timescale 1ns / 1ps

package whp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ChanW   = 16;
  localparam int unsigned BpsW    = 13;
  localparam int unsigned StatW   = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned DvsrW   = ChanW + BpsW;
  localparam int unsigned DivCntW = $clog2(WordW);

  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_HEADER,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_e;

  typedef enum logic {
    CTL_RUN,
    CTL_DIV
  } ctl_e;

  localparam logic [StatW-1:0] ST_PARSING = 2'd0;
  localparam logic [StatW-1:0] ST_READY   = 2'd1;
  localparam logic [StatW-1:0] ST_BAD_FMT = 2'd2;
  localparam logic [StatW-1:0] ST_ZERO    = 2'd3;

  // byte positions inside the preamble, a chunk header and the fmt body
  localparam logic [PosW-1:0] POS_PRE_LAST  = 4'd11;
  localparam logic [PosW-1:0] POS_HDR_SIZE  = 4'd4;
  localparam logic [PosW-1:0] POS_HDR_LAST  = 4'd7;
  localparam logic [PosW-1:0] POS_FMT_CODE  = 4'd1;
  localparam logic [PosW-1:0] POS_FMT_CHAN  = 4'd3;
  localparam logic [PosW-1:0] POS_FMT_RATE  = 4'd7;
  localparam logic [PosW-1:0] POS_FMT_LAST  = 4'd15;

  localparam logic [ChanW-1:0] FMT_PCM = 16'd1;

  localparam logic [WordW-1:0] TAG_FMT  = 32'h666d7420;
  localparam logic [WordW-1:0] TAG_DATA = 32'h64617461;

  localparam int unsigned NumSkip = 9;
  localparam logic [WordW-1:0] SKIP_TAGS [NumSkip] = '{
    32'h6c697374, 32'h66616374, 32'h63756520,
    32'h706c7374, 32'h6c61626c, 32'h6e6f7465,
    32'h6c747874, 32'h736d706c, 32'h696e7374
  };

  // letters lose bit 5, anything else stays
  function automatic logic [WordW-1:0] upper_tag(input logic [WordW-1:0] t);
    logic [ByteW-1:0] c;
    logic [WordW-1:0] r;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      c = t[ByteW*i +: ByteW];
      if (c >= 8'h61 && c <= 8'h7a) begin
        c = c - 8'h20;
      end
      r = {r[WordW-ByteW-1:0], c};
    end
    return r;
  endfunction

  function automatic logic name_is(input logic [WordW-1:0] name,
                                   input logic [WordW-1:0] lower);
    return (name == lower) || (name == upper_tag(lower));
  endfunction

endpackage

// ===== hw/rtl/whp_in_if.sv =====
`timescale 1ns / 1ps

interface whp_in_if;
  import whp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;
  logic             start_req;

  modport source (output valid, output byte_in, output start_req, input ready);
  modport sink   (input valid, input byte_in, input start_req, output ready);
endinterface

// ===== hw/rtl/whp_out_if.sv =====
`timescale 1ns / 1ps

interface whp_out_if;
  import whp_pkg::*;

  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [WordW-1:0] sample_rate;
  logic [ChanW-1:0] channel_count;
  logic [BpsW-1:0]  bytes_per_sample;
  logic [WordW-1:0] data_size;
  logic [WordW-1:0] sample_count;

  modport source (output valid, output status, output sample_rate, output channel_count,
                  output bytes_per_sample, output data_size, output sample_count,
                  input ready);
  modport sink   (input valid, input status, input sample_rate, input channel_count,
                  input bytes_per_sample, input data_size, input sample_count,
                  output ready);
endinterface

// ===== hw/rtl/whp_div.sv =====
`timescale 1ns / 1ps

module whp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [whp_pkg::WordW-1:0]   dividend_i,
  input  logic [whp_pkg::DvsrW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [whp_pkg::WordW-1:0]   quotient_o
);
  import whp_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DvsrW-1:0]   rem_q, rem_d;
  logic [DvsrW-1:0]   dvsr_q, dvsr_d;
  logic [WordW-1:0]   quo_q, quo_d;
  logic [DvsrW:0]     trial;
  logic [DvsrW:0]     diff;
  logic               ge;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign trial = {rem_q, quo_q[WordW-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign ge    = trial >= {1'b0, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvsr_d = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DvsrW-1:0] : trial[DvsrW-1:0];
      quo_d = {quo_q[WordW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    quo_q  <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/wav_header_parser_unit.sv =====
`timescale 1ns / 1ps

// WAV header parser: takes a file one byte per request, with start_req on the first byte,
// and answers every byte with one result request carrying the parse status and the
// format values held so far. Ordinary bytes pass at one per cycle unless results stall;
// the parse state registers are themselves the result register, so a new byte is taken
// in the cycle its predecessor's result is taken. The byte that completes a data chunk
// header with nonzero channels and bytes per sample waits for the sample count from a
// restoring divider that shares one 30-bit subtract-and-compare over 32 iterations,
// dividing the data size by the product of channels and bytes per sample. Bytes after a
// final status still get the same result, one per cycle, until the next start_req.
module wav_header_parser_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  whp_in_if.sink   in_i,
  whp_out_if.source out_o
);
  import whp_pkg::*;

  // handshake and sequencing
  ctl_e ctl_q, ctl_d;
  logic out_valid_q, out_valid_d;
  logic in_ready;
  logic in_fire;
  logic out_fire;
  logic launch;

  // parse state, also the visible result
  phase_e           phase_q, phase_d, phase_b;
  logic [PosW-1:0]  pos_q, pos_d, pos_b;
  logic [WordW-1:0] name_q, name_d, name_b;
  logic [WordW-1:0] size_q, size_d, size_b;
  logic [WordW-1:0] skip_q, skip_d, skip_b;
  logic [WordW-1:0] rate_q, rate_d, rate_b;
  logic [ChanW-1:0] chan_q, chan_d, chan_b;
  logic [BpsW-1:0]  bps_q, bps_d, bps_b;
  logic [StatW-1:0] fin_q, fin_d, fin_b;

  logic [WordW-1:0] fmt_word;
  logic             skip_hit;

  // divider
  logic [DvsrW-1:0] dvsr;
  logic             div_done;
  logic [WordW-1:0] div_quo;

  assign in_ready = (ctl_q == CTL_RUN) && (!out_valid_q || out_o.ready);
  assign in_fire  = in_i.valid && in_ready;
  assign out_fire = out_valid_q && out_o.ready;

  // next parse state for the byte on the input
  always_comb begin
    // a start request clears everything and the byte counts as preamble byte 0
    if (in_i.start_req) begin
      phase_b = PH_PREAMBLE;
      pos_b   = '0;
      name_b  = '0;
      size_b  = '0;
      skip_b  = '0;
      rate_b  = '0;
      chan_b  = '0;
      bps_b   = '0;
      fin_b   = ST_PARSING;
    end else begin
      phase_b = phase_q;
      pos_b   = pos_q;
      name_b  = name_q;
      size_b  = size_q;
      skip_b  = skip_q;
      rate_b  = rate_q;
      chan_b  = chan_q;
      bps_b   = bps_q;
      fin_b   = fin_q;
    end

    phase_d  = phase_b;
    pos_d    = pos_b;
    name_d   = name_b;
    size_d   = size_b;
    skip_d   = skip_b;
    rate_d   = rate_b;
    chan_d   = chan_b;
    bps_d    = bps_b;
    fin_d    = fin_b;
    launch   = 1'b0;
    fmt_word = {in_i.byte_in, size_b[WordW-1:ByteW]};
    skip_hit = 1'b0;

    unique case (phase_b)
      PH_PREAMBLE: begin
        if (pos_b == POS_PRE_LAST) begin
          pos_d   = '0;
          phase_d = PH_HEADER;
        end else begin
          pos_d = pos_b + 1'b1;
        end
      end

      PH_HEADER: begin
        // name shifts in big-endian, size shifts in little-endian
        if (pos_b < POS_HDR_SIZE) begin
          name_d = {name_b[WordW-ByteW-1:0], in_i.byte_in};
        end else begin
          size_d = fmt_word;
        end
        pos_d = pos_b + 1'b1;
        for (int i = 0; i < NumSkip; i++) begin
          skip_hit = skip_hit | name_is(name_d, SKIP_TAGS[i]);
        end
        if (pos_b == POS_HDR_LAST) begin
          pos_d = '0;
          if (name_is(name_d, TAG_FMT)) begin
            size_d  = '0;
            phase_d = PH_FMT;
          end else if (name_is(name_d, TAG_DATA)) begin
            phase_d = PH_DONE;
            if (chan_b == '0 || bps_b == '0) begin
              fin_d = ST_ZERO;
            end else begin
              fin_d  = ST_READY;
              launch = 1'b1;
            end
          end else if (skip_hit && size_d != '0) begin
            skip_d  = size_d;
            phase_d = PH_SKIP;
          end else begin
            // unknown name or empty skipped chunk: next header follows at once
            phase_d = PH_HEADER;
          end
        end
      end

      PH_FMT: begin
        size_d = fmt_word;
        pos_d  = pos_b + 1'b1;
        priority if (pos_b == POS_FMT_CODE) begin
          if (fmt_word[WordW-1:ChanW] != FMT_PCM) begin
            fin_d   = ST_BAD_FMT;
            phase_d = PH_DONE;
            pos_d   = pos_b;
          end
        end else if (pos_b == POS_FMT_CHAN) begin
          chan_d = fmt_word[WordW-1:ChanW];
        end else if (pos_b == POS_FMT_RATE) begin
          rate_d = fmt_word;
        end else if (pos_b == POS_FMT_LAST) begin
          // bits per sample divided by eight
          bps_d   = fmt_word[WordW-1:WordW-BpsW];
          pos_d   = '0;
          size_d  = '0;
          phase_d = PH_HEADER;
        end else begin
          pos_d = pos_b + 1'b1;
        end
      end

      PH_SKIP: begin
        skip_d = skip_b - 1'b1;
        if (skip_d == '0) begin
          pos_d   = '0;
          phase_d = PH_HEADER;
        end
      end

      PH_DONE: begin
        // final status holds until the next start request
      end

      default: begin
      end
    endcase
  end

  // sequencer: run bytes, or wait for the divider after a data header
  always_comb begin
    ctl_d       = ctl_q;
    out_valid_d = out_valid_q;
    unique case (ctl_q)
      CTL_RUN: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
        end
        if (in_fire) begin
          if (launch) begin
            ctl_d       = CTL_DIV;
            out_valid_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      CTL_DIV: begin
        if (div_done) begin
          ctl_d       = CTL_RUN;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        ctl_d = CTL_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_RUN;
      out_valid_q <= 1'b0;
      phase_q     <= PH_PREAMBLE;
      pos_q       <= '0;
      name_q      <= '0;
      size_q      <= '0;
      skip_q      <= '0;
      rate_q      <= '0;
      chan_q      <= '0;
      bps_q       <= '0;
      fin_q       <= ST_PARSING;
    end else begin
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        name_q  <= name_d;
        size_q  <= size_d;
        skip_q  <= skip_d;
        rate_q  <= rate_d;
        chan_q  <= chan_d;
        bps_q   <= bps_d;
        fin_q   <= fin_d;
      end
    end
  end

  // a / b / c equals a / (b * c) for unsigned integers; the product fits 29 bits
  assign dvsr = DvsrW'(chan_q) * DvsrW'(bps_q);

  whp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && launch),
    .dividend_i (size_d),
    .divisor_i  (dvsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_i.ready = in_ready;

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = (phase_q == PH_DONE) ? fin_q : ST_PARSING;
  assign out_o.sample_rate      = rate_q;
  assign out_o.channel_count    = chan_q;
  assign out_o.bytes_per_sample = bps_q;
  assign out_o.data_size        = ((phase_q == PH_DONE) &&
                                   (fin_q == ST_READY || fin_q == ST_ZERO)) ? size_q : '0;
  assign out_o.sample_count     = ((phase_q == PH_DONE) && (fin_q == ST_READY)) ?
                                  div_quo : '0;

  // no byte taken and no result shown while the divider runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q == CTL_DIV |-> !in_ready && !out_valid_q)
    else $error("request moved while divider busy");

  // divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ctl_q == CTL_DIV)
    else $error("divider done outside divide state");

  // a ready header always has a nonzero divisor behind its sample count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && phase_q == PH_DONE && fin_q == ST_READY) |-> dvsr != '0)
    else $error("ready header with zero divisor");

  // a launch always leads into the divide state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && launch) |=> ctl_q == CTL_DIV)
    else $error("division launched without waiting");

endmodule
